// File: rtl/core/ddcb_pkg.sv
// Shared types, constants and codes for the DMA descriptor chain builder.
`timescale 1ns / 1ps

package ddcb_pkg;

    localparam int MAX_DESCRIPTORS_DEF  = 64;
    localparam int DESCRIPTOR_BYTES_DEF = 32;

    localparam logic [15:0] MAX_XFER_RESET = 16'd256;
    localparam logic [31:0] DUMMY_RESET    = 32'd0;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  REG_MAX_XFER = 1'b0;
    localparam logic [0:0]  REG_DUMMY    = 1'b1;

    // transfer types
    localparam logic [1:0] TT_P2M     = 2'd0;
    localparam logic [1:0] TT_M2P     = 2'd1;
    localparam logic [1:0] TT_M2M     = 2'd2;
    localparam logic [1:0] TT_INVALID = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_BOTH_ZERO = 3'd2;
    localparam logic [2:0] ST_SIZE_ZERO = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;
    localparam logic [2:0] ST_NO_DUMMY  = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]  transfer_type;
        logic [31:0] source_address;
        logic [31:0] target_address;
        logic [31:0] byte_length;
        logic [3:0]  source_width;
        logic [3:0]  target_width;
        logic [31:0] channel_control;
        logic [3:0]  link_flag;
        logic [31:0] list_base_addr;
    } t_in_req;

    typedef struct packed {
        logic [31:0] next_link;
        logic [15:0] chunk_bytes;
        logic [31:0] chunk_source;
        logic [31:0] chunk_target;
        logic [31:0] control_out;
        logic        is_m2m_chunk;
        logic        last_item;
        logic [2:0]  status;
    } t_out_item;

    // divider handshake between sequencer and shared divide unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

// File: rtl/core/dma_descriptor_chain_builder.sv
// Top level of the DMA descriptor chain builder: config registers and sequencer.
//
//   Channel  Direction  Handshake               Payload
//   in       input      i_in_valid / o_in_ready t_in_req     (one transfer request)
//   out      output     o_out_valid/i_out_ready t_out_item   (descriptor, chunk or status)
//   cfg      input      i_cfg_we                i_cfg_index, i_cfg_data
//
// One pass of the shared 32-step divider (two when the chunk is rounded to an
// access width) precedes the first result; then one descriptor or chunk leaves per
// cycle while taken. An error found at accept is registered via the error state once
// the output is free. Input is refused until the request's last result is registered.
// Reset (synchronous, active low) idles the sequencer, empties the output register and
// loads max_transfer_size = 256, dummy_buffer_addr = 0; a stalled output holds its result.
`timescale 1ns / 1ps

module dma_descriptor_chain_builder
    import ddcb_pkg::*;
#(
    parameter int MAX_DESC   = MAX_DESCRIPTORS_DEF,
    parameter int DESC_BYTES = DESCRIPTOR_BYTES_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out
);

    // configuration registers
    logic [15:0] r_max_xfer, n_max_xfer;
    logic [31:0] r_dummy, n_dummy;

    always_comb begin
        n_max_xfer = r_max_xfer;
        n_dummy    = r_dummy;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_XFER: n_max_xfer = i_cfg_data[15:0];
                REG_DUMMY:    n_dummy    = i_cfg_data;
                default:      n_dummy    = r_dummy;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_xfer <= MAX_XFER_RESET;
            r_dummy    <= DUMMY_RESET;
        end else begin
            r_max_xfer <= n_max_xfer;
            r_dummy    <= n_dummy;
        end
    end

    // sequencer with the shared divider: round, count, check, then emit
    ddcb_seq #(
        .MAX_DESC   (MAX_DESC),
        .DESC_BYTES (DESC_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_xfer  (r_max_xfer),
        .i_dummy     (r_dummy),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/ddcb_div.sv
// Shared restoring divider: 32-bit dividend, 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module ddcb_div
    import ddcb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_quot, n_quot;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_div, n_div;

    logic [16:0] w_shift;
    logic [16:0] w_diff;

    assign w_shift = {r_rem, r_quot[31]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_quot = i_req.dividend;
            n_rem  = 16'd0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_div}) begin
                n_rem  = w_diff[15:0];
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = w_shift[15:0];
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// File: rtl/core/ddcb_seq.sv
// Request sequencer: size rounding, chunk count, checks and descriptor emission.
`timescale 1ns / 1ps

module ddcb_seq
    import ddcb_pkg::*;
#(
    parameter int MAX_DESC   = MAX_DESCRIPTORS_DEF,
    parameter int DESC_BYTES = DESCRIPTOR_BYTES_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_xfer,
    input  logic [31:0] i_dummy,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int          CW   = $clog2(MAX_DESC + 1);
    localparam logic [31:0] DB32 = 32'(DESC_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    t_in_req       r_req, n_req;
    logic [2:0]    r_status, n_status;
    logic [15:0]   r_size, n_size;
    logic [15:0]   r_rem, n_rem;
    logic [31:0]   r_src, n_src;
    logic [31:0]   r_dst, n_dst;
    logic [31:0]   r_link, n_link;
    logic [CW-1:0] r_left, n_left;
    logic          r_adv_src, n_adv_src;
    logic          r_adv_dst, n_adv_dst;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic        w_accept;
    logic        w_slot_free;
    logic [3:0]  w_width;
    logic [15:0] w_size_mod;
    logic [32:0] w_count;
    logic [31:0] w_src_eff;
    logic [31:0] w_dst_eff;
    logic        w_is_m2m;
    logic        w_last;
    logic [15:0] w_cnt;

    ddcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_width     = (i_in.source_width >= i_in.target_width) ? i_in.source_width
                                                                  : i_in.target_width;
    assign w_size_mod  = i_max_xfer - w_div_rsp.rem;
    assign w_count     = {1'b0, w_div_rsp.quot} + {32'd0, (w_div_rsp.rem != 16'd0)};
    assign w_src_eff   = (r_req.source_address == 32'd0) ? i_dummy : r_req.source_address;
    assign w_dst_eff   = (r_req.target_address == 32'd0) ? i_dummy : r_req.target_address;
    assign w_is_m2m    = (r_req.transfer_type == TT_M2M);
    assign w_last      = (r_left == CW'(1));
    assign w_cnt       = (w_last && (r_rem != 16'd0)) ? r_rem : r_size;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_req       = r_req;
        n_status    = r_status;
        n_size      = r_size;
        n_rem       = r_rem;
        n_src       = r_src;
        n_dst       = r_dst;
        n_link      = r_link;
        n_left      = r_left;
        n_adv_src   = r_adv_src;
        n_adv_dst   = r_adv_dst;
        w_div_req   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req = i_in;
                    if (i_in.transfer_type == TT_INVALID) begin
                        n_status = ST_BAD_TYPE;
                        n_state  = S_ERR;
                    end else if (i_in.transfer_type == TT_M2M) begin
                        if (i_max_xfer == 16'd0) begin
                            n_status = ST_SIZE_ZERO;
                            n_state  = S_ERR;
                        end else begin
                            n_size             = i_max_xfer;
                            w_div_req.start    = 1'b1;
                            w_div_req.dividend = i_in.byte_length;
                            w_div_req.divisor  = i_max_xfer;
                            n_state            = S_DIV;
                        end
                    end else if (i_in.source_address == 32'd0 &&
                                 i_in.target_address == 32'd0) begin
                        n_status = ST_BOTH_ZERO;
                        n_state  = S_ERR;
                    end else if (w_width == 4'd0) begin
                        if (i_max_xfer == 16'd0) begin
                            n_status = ST_SIZE_ZERO;
                            n_state  = S_ERR;
                        end else begin
                            n_size             = i_max_xfer;
                            w_div_req.start    = 1'b1;
                            w_div_req.dividend = i_in.byte_length;
                            w_div_req.divisor  = i_max_xfer;
                            n_state            = S_DIV;
                        end
                    end else begin
                        // round max size down to the access width first
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = {16'd0, i_max_xfer};
                        w_div_req.divisor  = {12'd0, w_width};
                        n_state            = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_div_rsp.done) begin
                    if (w_size_mod == 16'd0) begin
                        n_status = ST_SIZE_ZERO;
                        n_state  = S_ERR;
                    end else begin
                        n_size             = w_size_mod;
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = r_req.byte_length;
                        w_div_req.divisor  = w_size_mod;
                        n_state            = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_rem  = w_div_rsp.rem;
                    n_left = w_count[CW-1:0];
                    n_link = r_req.list_base_addr + DB32 + {28'd0, r_req.link_flag};
                    if (w_is_m2m) begin
                        n_src     = r_req.source_address;
                        n_dst     = r_req.target_address;
                        n_adv_src = 1'b1;
                        n_adv_dst = 1'b1;
                    end else begin
                        n_src     = w_src_eff;
                        n_dst     = w_dst_eff;
                        n_adv_src = (r_req.transfer_type == TT_M2P) &&
                                    (r_req.source_address != 32'd0);
                        n_adv_dst = (r_req.transfer_type == TT_P2M) &&
                                    (r_req.target_address != 32'd0);
                    end
                    if (w_count > 33'(MAX_DESC)) begin
                        n_status = ST_TOO_MANY;
                        n_state  = S_ERR;
                    end else if (!w_is_m2m &&
                                 (w_src_eff == 32'd0 || w_dst_eff == 32'd0)) begin
                        n_status = ST_NO_DUMMY;
                        n_state  = S_ERR;
                    end else if (w_count == 33'd0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_ERR;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.next_link    = (w_is_m2m || w_last) ? 32'd0 : r_link;
                    n_out.chunk_bytes  = w_cnt;
                    n_out.chunk_source = r_src;
                    n_out.chunk_target = r_dst;
                    n_out.control_out  = r_req.channel_control;
                    n_out.is_m2m_chunk = w_is_m2m;
                    n_out.last_item    = w_last;
                    n_out.status       = ST_OK;
                    n_link             = r_link + DB32;
                    n_left             = r_left - CW'(1);
                    if (r_adv_src) begin
                        n_src = r_src + {16'd0, w_cnt};
                    end
                    if (r_adv_dst) begin
                        n_dst = r_dst + {16'd0, w_cnt};
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (w_slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.last_item = 1'b1;
                    n_out.status    = r_status;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out     <= n_out;
        r_req     <= n_req;
        r_status  <= n_status;
        r_size    <= n_size;
        r_rem     <= n_rem;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_link    <= n_link;
        r_left    <= n_left;
        r_adv_src <= n_adv_src;
        r_adv_dst <= n_adv_dst;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: test/dma_descriptor_chain_builder_tb.sv
// Self-checking testbench for the DMA descriptor chain builder: directed and random requests.
`timescale 1ns / 1ps

module dma_descriptor_chain_builder_tb;
    import ddcb_pkg::*;

    localparam int MAX_DESC       = MAX_DESCRIPTORS_DEF;
    localparam int DESC_BYTES     = DESCRIPTOR_BYTES_DEF;
    // A rounded peripheral request makes two divider passes before its first result.
    localparam int SETTLE_CYCLES  = 100;
    // Longest quiet stretch of a correct run is the long hold-off plus one request.
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRINT_CAP      = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in_req              in_req    = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    t_out_item            out_item;

    // Shadow copy of the configuration registers, at their reset values.
    logic [15:0] cfg_max_xfer = MAX_XFER_RESET;
    logic [31:0] cfg_dummy    = DUMMY_RESET;

    // Descriptors, chunks and status items still owed by the block, oldest first.
    t_out_item desc_expect_q[$];

    int  err_count     = 0;
    int  quiet_cycles  = 0;
    int  hold_off_left = 0;
    int  stall_left    = 0;
    bit  bursts_on     = 1'b1;

    dma_descriptor_chain_builder #(
        .MAX_DESC   (MAX_DESC),
        .DESC_BYTES (DESC_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue the single status item of a rejected or empty request.
    function automatic void push_status(logic [2:0] code);
        t_out_item d;
        d           = '0;
        d.last_item = 1'b1;
        d.status    = code;
        desc_expect_q.push_back(d);
    endfunction

    // Work out every item that one accepted request produces.
    function automatic void predict_descriptors(t_in_req r);
        logic [31:0] size;
        logic [31:0] rem;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] off;
        logic [31:0] cnt;
        logic [32:0] n;
        logic [3:0]  w;
        bit          sdum;
        bit          ddum;
        bit          last;
        t_out_item   d;
        sdum = 1'b0;
        ddum = 1'b0;
        size = {16'd0, cfg_max_xfer};
        if (r.transfer_type == TT_INVALID) begin
            push_status(ST_BAD_TYPE);
            return;
        end
        if (r.transfer_type == TT_M2M) begin
            // Unaligned chunks, both sides advance, addresses taken as given.
            if (size == 0) begin
                push_status(ST_SIZE_ZERO);
                return;
            end
            rem = r.byte_length % size;
            n   = {1'b0, r.byte_length / size} + ((rem != 0) ? 33'd1 : 33'd0);
            if (n > 33'(MAX_DESC)) begin
                push_status(ST_TOO_MANY);
                return;
            end
            if (n == 0) begin
                push_status(ST_EMPTY);
                return;
            end
            for (int i = 0; i < int'(n); i++) begin
                off            = 32'(i) * size;
                cnt            = (r.byte_length - off >= size) ? size : r.byte_length - off;
                d              = '0;
                d.chunk_bytes  = cnt[15:0];
                d.chunk_source = r.source_address + off;
                d.chunk_target = r.target_address + off;
                d.control_out  = r.channel_control;
                d.is_m2m_chunk = 1'b1;
                d.last_item    = (i + 1 == int'(n));
                desc_expect_q.push_back(d);
            end
            return;
        end
        // Peripheral request: round the chunk down to the wider access width.
        w = (r.source_width >= r.target_width) ? r.source_width : r.target_width;
        if (r.source_address == 0 && r.target_address == 0) begin
            push_status(ST_BOTH_ZERO);
            return;
        end
        if (w != 0)
            size = size - size % {28'd0, w};
        if (size == 0) begin
            push_status(ST_SIZE_ZERO);
            return;
        end
        rem = r.byte_length % size;
        n   = {1'b0, r.byte_length / size} + ((rem != 0) ? 33'd1 : 33'd0);
        if (n > 33'(MAX_DESC)) begin
            push_status(ST_TOO_MANY);
            return;
        end
        src = r.source_address;
        dst = r.target_address;
        if (src == 0) begin
            src  = cfg_dummy;
            sdum = 1'b1;
        end
        if (dst == 0) begin
            dst  = cfg_dummy;
            ddum = 1'b1;
        end
        if (src == 0 || dst == 0) begin
            push_status(ST_NO_DUMMY);
            return;
        end
        if (n == 0) begin
            push_status(ST_EMPTY);
            return;
        end
        for (int i = 0; i < int'(n); i++) begin
            last           = (i + 1 == int'(n));
            cnt            = (!last || rem == 0) ? size : rem;
            d              = '0;
            d.next_link    = last ? 32'd0 :
                             r.list_base_addr + 32'(i + 1) * 32'(DESC_BYTES)
                             + {28'd0, r.link_flag};
            d.chunk_bytes  = cnt[15:0];
            d.chunk_source = src;
            d.chunk_target = dst;
            d.control_out  = r.channel_control;
            d.last_item    = last;
            desc_expect_q.push_back(d);
            // Advance the memory side only, and never a dummy side.
            if (r.transfer_type == TT_P2M && !ddum)
                dst = dst + cnt;
            if (r.transfer_type == TT_M2P && !sdum)
                src = src + cnt;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    // Fill a request; control word, link flag and list base are random.
    function automatic t_in_req make_request(logic [1:0] kind, logic [31:0] src,
                                             logic [31:0] dst, logic [31:0] len,
                                             logic [3:0] sw, logic [3:0] dw);
        t_in_req r;
        r.transfer_type   = kind;
        r.source_address  = src;
        r.target_address  = dst;
        r.byte_length     = len;
        r.source_width    = sw;
        r.target_width    = dw;
        r.channel_control = $urandom();
        r.link_flag       = 4'($urandom_range(0, 15));
        r.list_base_addr  = $urandom();
        return r;
    endfunction

    // Mostly random addresses, with zero and near-wrap values mixed in.
    function automatic logic [31:0] rand_addr();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        return $urandom();
    endfunction

    // Access widths: legal 0..8 mostly, oversized now and then.
    function automatic logic [3:0] rand_width();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // Keep most requests within the descriptor limit so that runs get built.
    function automatic t_in_req random_request();
        t_in_req     r;
        int unsigned pick;
        int unsigned span;
        r.transfer_type   = ($urandom_range(0, 19) == 0) ? TT_INVALID
                                                          : 2'($urandom_range(0, 2));
        r.source_address  = rand_addr();
        r.target_address  = rand_addr();
        r.source_width    = rand_width();
        r.target_width    = rand_width();
        r.channel_control = $urandom();
        r.link_flag       = 4'($urandom_range(0, 15));
        r.list_base_addr  = rand_addr();
        span = (cfg_max_xfer == 0) ? 1 : cfg_max_xfer;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            r.byte_length = 32'd0;
        else if (pick == 1)
            r.byte_length = $urandom();
        else if (pick == 2)
            r.byte_length = span * MAX_DESC + $urandom_range(0, span);
        else if (pick <= 5)
            r.byte_length = $urandom_range(0, span * MAX_DESC);
        else
            r.byte_length = $urandom_range(1, span * 8);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request, hold it until accepted, then maybe idle a burst.
    task automatic send_request(t_in_req r);
        int unsigned gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_descriptors(r);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, wait until every owed item is back, then let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (desc_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; only call while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_MAX_XFER)
            cfg_max_xfer = data[15:0];
        else if (idx == REG_DUMMY)
            cfg_dummy = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: long hold-off when requested, otherwise random stall bursts while bursts are on.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_left > 0) begin
                out_ready <= 1'b0;
                hold_off_left--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (bursts_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got_v, exp_v);
        err_count++;
    endtask

    // Compare every taken result with the oldest owed item.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (desc_expect_q.size() == 0) begin
                report_mismatch("unexpected result, chunk_source",
                                out_item.chunk_source, 32'd0);
            end else begin
                want = desc_expect_q.pop_front();
                if (out_item.next_link !== want.next_link)
                    report_mismatch("next_link", out_item.next_link, want.next_link);
                if (out_item.chunk_bytes !== want.chunk_bytes)
                    report_mismatch("chunk_bytes", 32'(out_item.chunk_bytes),
                                    32'(want.chunk_bytes));
                if (out_item.chunk_source !== want.chunk_source)
                    report_mismatch("chunk_source", out_item.chunk_source, want.chunk_source);
                if (out_item.chunk_target !== want.chunk_target)
                    report_mismatch("chunk_target", out_item.chunk_target, want.chunk_target);
                if (out_item.control_out !== want.control_out)
                    report_mismatch("control_out", out_item.control_out, want.control_out);
                if (out_item.is_m2m_chunk !== want.is_m2m_chunk)
                    report_mismatch("is_m2m_chunk", 32'(out_item.is_m2m_chunk),
                                    32'(want.is_m2m_chunk));
                if (out_item.last_item !== want.last_item)
                    report_mismatch("last_item", 32'(out_item.last_item),
                                    32'(want.last_item));
                if (out_item.status !== want.status)
                    report_mismatch("status", 32'(out_item.status), 32'(want.status));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: every request type and every error code but the zero chunk size.
    task automatic test_reset_config();
        send_request(make_request(TT_P2M, 32'h1000_0000, 32'h2000_0000, 32'd1000, 4'd4, 4'd4));
        send_request(make_request(TT_M2P, 32'h3000_0000, 32'h4000_0000, 32'd256, 4'd1, 4'd2));
        send_request(make_request(TT_M2M, $urandom(), $urandom(), 32'd700, 4'd8, 4'd0));
        send_request(make_request(TT_INVALID, $urandom(), $urandom(), 32'd64, 4'd0, 4'd0));
        send_request(make_request(TT_P2M, 32'd0, 32'd0, 32'd512, 4'd0, 4'd0));
        // zero source with no dummy buffer configured
        send_request(make_request(TT_P2M, 32'd0, 32'h5000_0000, 32'd512, 4'd0, 4'd0));
        send_request(make_request(TT_M2P, 32'h6000_0000, 32'h7000_0000, 32'd0, 4'd2, 4'd2));
        send_request(make_request(TT_M2M, 32'h6000_0000, 32'h7000_0000, 32'd0, 4'd0, 4'd0));
        // exactly the descriptor limit, then one byte past it
        send_request(make_request(TT_P2M, 32'h8000_0000, 32'h9000_0000,
                                  32'(256 * MAX_DESC), 4'd0, 4'd0));
        send_request(make_request(TT_M2M, 32'h8000_0000, 32'h9000_0000,
                                  32'(256 * MAX_DESC + 1), 4'd0, 4'd0));
        send_request(make_request(TT_P2M, 32'hA000_0000, 32'hB000_0000,
                                  32'hFFFF_FFFF, 4'd1, 4'd1));
        wait_idle();
    endtask

    // Dummy buffer substitution and address wrap at the field extremes.
    task automatic test_dummy_and_wrap();
        t_in_req r;
        write_reg(REG_MAX_XFER, 32'd65535);
        write_reg(REG_DUMMY, 32'hFFFF_FFFF);
        // dummy target stays put; links wrap past the top of memory
        r = make_request(TT_P2M, 32'h4000_0000, 32'd0, 32'd200000, 4'd8, 4'd0);
        r.list_base_addr = 32'hFFFF_FFF0;
        r.link_flag      = 4'hF;
        send_request(r);
        // dummy source stays put
        send_request(make_request(TT_M2P, 32'd0, 32'h1234_5670, 32'(65535 * 2 + 5),
                                  4'd0, 4'd4));
        // memory to memory takes a zero address as given and wraps
        send_request(make_request(TT_M2M, 32'd0, 32'hFFFF_0000, 32'(65535 * 3), 4'd0, 4'd0));
        send_request(make_request(TT_P2M, 32'h0000_0010, 32'hFFFF_FFF0, 32'(65535 * 3),
                                  4'd0, 4'd1));
        wait_idle();
    endtask

    // Rounding to the access width, oversized widths, zero chunk size.
    task automatic test_alignment();
        write_reg(REG_MAX_XFER, 32'd7);
        send_request(make_request(TT_P2M, 32'h0100_0000, 32'h0200_0000, 32'd40, 4'd3, 4'd2));
        send_request(make_request(TT_M2P, 32'h0100_0000, 32'h0200_0000, 32'd40, 4'd8, 4'd0));
        send_request(make_request(TT_P2M, 32'h0100_0000, 32'h0200_0000, 32'd40, 4'd15, 4'd9));
        send_request(make_request(TT_M2P, 32'h0100_0000, 32'h0200_0000, 32'd50, 4'd0, 4'd0));
        // both addresses zero is reported ahead of the zero chunk size
        send_request(make_request(TT_P2M, 32'd0, 32'd0, 32'd40, 4'd8, 4'd8));
        wait_idle();
        write_reg(REG_MAX_XFER, 32'd0);
        send_request(make_request(TT_M2M, 32'h0100_0000, 32'h0200_0000, 32'd40, 4'd0, 4'd0));
        send_request(make_request(TT_P2M, 32'h0100_0000, 32'h0200_0000, 32'd40, 4'd0, 4'd0));
        wait_idle();
    endtask

    // Random requests under several register settings, extremes included.
    task automatic test_random_sweep();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MAX_XFER, 32'd256);
                    write_reg(REG_DUMMY, $urandom() | 32'd1);
                end
                1: begin
                    write_reg(REG_MAX_XFER, 32'd1);
                    write_reg(REG_DUMMY, 32'd0);
                end
                2: begin
                    write_reg(REG_MAX_XFER, 32'd65535);
                    write_reg(REG_DUMMY, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(REG_MAX_XFER, $urandom_range(2, 4096));
                    write_reg(REG_DUMMY, $urandom());
                end
            endcase
            repeat (80) send_request(random_request());
            wait_idle();
        end
    endtask

    // Hold the receiver off so the block backs up; later pause until drained.
    task automatic test_backpressure();
        write_reg(REG_MAX_XFER, 32'd64);
        write_reg(REG_DUMMY, $urandom() | 32'd1);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (12) send_request(random_request());
        wait_idle();
        repeat (28) send_request(random_request());
        wait_idle();
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_full_rate();
        bursts_on = 1'b0;
        write_reg(REG_MAX_XFER, $urandom_range(1, 65535));
        write_reg(REG_DUMMY, $urandom());
        repeat (70) send_request(random_request());
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_dummy_and_wrap();
        test_alignment();
        test_random_sweep();
        test_backpressure();
        test_full_rate();
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ddcb_pkg.sv
rtl/core/ddcb_div.sv
rtl/core/ddcb_seq.sv
rtl/core/dma_descriptor_chain_builder.sv
test/dma_descriptor_chain_builder_tb.sv
